/* rtl/mps_pkg.sv */
package mps_pkg;

  localparam int AXES       = 3;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W + 1;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [SAMPLE_W-1:0] OVF_VALUE = 16'h7FFF;
  localparam logic [CNT_W-1:0]    CNT_MAX   = 8'hFF;

  // Axes whose magnitudes feed the mode machine: x and y.
  localparam logic [AXES-1:0] MODE_AXES = 3'b011;

  localparam logic [CFG_IDX_W-1:0] REG_ENTER_THRESH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTER_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SET_ONLY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_SWITCH  = 3'd5;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_SET_ONLY  = 2'd1,
    CMD_SET_RESET = 2'd2
  } mode_cmd_t;

  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_OVF  = 2'd1,
    SEL_PASS = 2'd2
  } sel_t;

  typedef struct packed {
    logic above_enter;
    logic below_exit;
  } lane_flags_t;

  typedef struct packed {
    logic [CNT_W-1:0] enter_count;
    logic [CNT_W-1:0] max_set_only;
    logic [CNT_W-1:0] fail_limit;
    logic             auto_switch;
  } merge_cfg_t;

  typedef struct packed {
    logic      recover;
    mode_cmd_t cmd;
    logic      set_only;
  } merge_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

/* rtl/mps_lane.sv */
module mps_lane import mps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  sel_t                sel,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic [SAMPLE_W-1:0] enter_thresh,
  input  logic [SAMPLE_W-1:0] exit_thresh,
  output logic [SAMPLE_W-1:0] sample_out,
  output lane_flags_t         flags
);

  logic [SAMPLE_W-1:0] held_r;
  logic [MAG_W-1:0]    mag;

  always_comb begin
    case (sel)
      SEL_PASS: sample_out = sample_in;
      SEL_OVF:  sample_out = OVF_VALUE;
      SEL_HOLD: sample_out = held_r;
      default:  sample_out = held_r;
    endcase
  end

  assign mag = sample_out[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - {1'b0, sample_out}
                                      : {1'b0, sample_out};

  assign flags.above_enter = mag > {1'b0, enter_thresh};
  assign flags.below_exit  = mag < {1'b0, exit_thresh};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (take) begin
      held_r <= sample_out;
    end
  end

endmodule

/* rtl/mps_merge.sv */
module mps_merge import mps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic        bad_status,
  input  logic        overflow,
  input  lane_flags_t flags [AXES],
  input  merge_cfg_t  cfg,
  output merge_res_t  res
);

  logic [CNT_W-1:0] fail_r, fail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic             mode_r, mode_nxt;
  logic             any_above, all_below;
  logic             recover;
  mode_cmd_t        cmd;

  always_comb begin
    any_above = 1'b0;
    all_below = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (MODE_AXES[i]) begin
        any_above = any_above | flags[i].above_enter;
        all_below = all_below & flags[i].below_exit;
      end
    end
  end

  always_comb begin
    recover  = 1'b0;
    fail_nxt = fail_r;
    if (bad_status) begin
      if (fail_r > cfg.fail_limit) begin
        recover  = 1'b1;
        fail_nxt = '0;
      end else begin
        fail_nxt = sat_inc(fail_r);
      end
    end else if (!overflow) begin
      fail_nxt = '0;
    end
  end

  always_comb begin
    cnt_inc  = sat_inc(cnt_r);
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    cmd      = CMD_NONE;
    if (cfg.auto_switch) begin
      if (!mode_r) begin
        if (any_above) begin
          if (cnt_inc >= cfg.enter_count) begin
            mode_nxt = 1'b1;
            cnt_nxt  = '0;
            cmd      = CMD_SET_ONLY;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          cnt_nxt = '0;
        end
      end else begin
        if (all_below || cnt_inc >= cfg.max_set_only) begin
          mode_nxt = 1'b0;
          cnt_nxt  = '0;
          cmd      = CMD_SET_RESET;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  assign res = '{recover: recover, cmd: cmd, set_only: mode_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r <= '0;
      cnt_r  <= '0;
      mode_r <= 1'b0;
    end else if (take) begin
      fail_r <= fail_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

/* rtl/magnetometer_sample_qualifier.sv */
// A result appears in the output register in the cycle after its request is accepted.
// One request per cycle while out_ready is high; the three axis lanes and the mode merge
// finish in that cycle, and a new request is taken in the cycle the waiting result leaves.
// Reset (synchronous, active low) clears held samples, failure and mode counters,
// selects set-reset mode and loads the configuration registers with their defaults.
module magnetometer_sample_qualifier import mps_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_status_read_ok,
  input  logic                         in_data_ready,
  input  logic                         in_overflow,
  input  logic                         in_data_read_ok,
  input  logic signed [SAMPLE_W-1:0]   in_x_sample,
  input  logic signed [SAMPLE_W-1:0]   in_y_sample,
  input  logic signed [SAMPLE_W-1:0]   in_z_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   out_x_out,
  output logic signed [SAMPLE_W-1:0]   out_y_out,
  output logic signed [SAMPLE_W-1:0]   out_z_out,
  output logic                         out_recover_request,
  output logic [1:0]                   out_mode_command,
  output logic                         out_set_only_active,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  logic [SAMPLE_W-1:0] enter_thresh_r, exit_thresh_r;
  merge_cfg_t          mcfg_r;

  logic                take, bad_status;
  sel_t                sel;
  logic [SAMPLE_W-1:0] lane_in  [AXES];
  logic [SAMPLE_W-1:0] lane_out [AXES];
  lane_flags_t         flags    [AXES];
  merge_res_t          res;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] x_r, y_r, z_r;
  merge_res_t          res_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;

  assign bad_status = !in_status_read_ok || !in_data_ready;

  always_comb begin
    if (bad_status) begin
      sel = SEL_HOLD;
    end else if (in_overflow) begin
      sel = SEL_OVF;
    end else if (in_data_read_ok) begin
      sel = SEL_PASS;
    end else begin
      sel = SEL_HOLD;
    end
  end

  assign lane_in[0] = in_x_sample;
  assign lane_in[1] = in_y_sample;
  assign lane_in[2] = in_z_sample;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    mps_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .take         (take),
      .sel          (sel),
      .sample_in    (lane_in[g]),
      .enter_thresh (enter_thresh_r),
      .exit_thresh  (exit_thresh_r),
      .sample_out   (lane_out[g]),
      .flags        (flags[g])
    );
  end

  mps_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .bad_status (bad_status),
    .overflow   (in_overflow),
    .flags      (flags),
    .cfg        (mcfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_thresh_r      <= 16'd8000;
      exit_thresh_r       <= 16'd6000;
      mcfg_r.enter_count  <= 8'd10;
      mcfg_r.max_set_only <= 8'd100;
      mcfg_r.fail_limit   <= 8'd10;
      mcfg_r.auto_switch  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENTER_THRESH: enter_thresh_r      <= cfg_data;
        REG_EXIT_THRESH:  exit_thresh_r       <= cfg_data;
        REG_ENTER_COUNT:  mcfg_r.enter_count  <= cfg_data[CNT_W-1:0];
        REG_MAX_SET_ONLY: mcfg_r.max_set_only <= cfg_data[CNT_W-1:0];
        REG_FAIL_LIMIT:   mcfg_r.fail_limit   <= cfg_data[CNT_W-1:0];
        REG_AUTO_SWITCH:  mcfg_r.auto_switch  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r   <= lane_out[0];
      y_r   <= lane_out[1];
      z_r   <= lane_out[2];
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_x_out           = x_r;
  assign out_y_out           = y_r;
  assign out_z_out           = z_r;
  assign out_recover_request = res_r.recover;
  assign out_mode_command    = res_r.cmd;
  assign out_set_only_active = res_r.set_only;

endmodule
